FILE: sv/kct_pkg.sv
package kct_pkg;

  // default table geometry
  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_COUNT_BITS    = 16;

  // fixed field widths
  localparam int KEY_BITS    = 24;
  localparam int AMOUNT_BITS = 16;
  localparam int COUNT_OUT_BITS = 16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_LIST      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD   = 2'd1,
    S_EV   = 2'd2,
    S_END  = 2'd3
  } state_t;

  // which result the datapath loads into the output register
  typedef enum logic [1:0] {
    EM_HIT  = 2'd0,
    EM_PEND = 2'd1,
    EM_END  = 2'd2
  } emit_src_t;

  typedef struct packed {
    logic      load_item;
    logic      inc_idx;
    logic      rd_en;
    logic      wr_hit;
    logic      wr_ins;
    logic      load_pend;
    logic      emit;
    emit_src_t emit_src;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  used_zero;
    logic  idx_last;
    logic  key_match;
    logic  cnt_nonzero;
    logic  pend_valid;
    logic  table_full;
    logic  out_free;
  } dp_stat_t;

endpackage

FILE: sv/kct_ctrl.sv
module kct_ctrl
  import kct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_kind,
  output logic        in_ready,
  input  dp_stat_t    stat,
  output ctl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.emit_src = EM_HIT;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (kind_t'(in_kind) == KIND_IGNORE) begin
            state_next = S_IDLE;
          end else if (stat.used_zero) begin
            state_next = S_END;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (stat.kind != KIND_LIST) begin
          // search for the key
          if (stat.key_match) begin
            if (stat.out_free) begin
              cmd.wr_hit   = 1'b1;
              cmd.emit     = 1'b1;
              cmd.emit_src = EM_HIT;
              state_next   = S_IDLE;
            end
          end else if (stat.idx_last) begin
            state_next = S_END;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = S_RD;
          end
        end else if (!(stat.cnt_nonzero && stat.pend_valid && !stat.out_free)) begin
          // list sweep: a new nonzero entry pushes out the held one
          if (stat.cnt_nonzero) begin
            cmd.load_pend = 1'b1;
            if (stat.pend_valid) begin
              cmd.emit     = 1'b1;
              cmd.emit_src = EM_PEND;
            end
          end
          if (stat.idx_last) begin
            state_next = S_END;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = EM_END;
          cmd.wr_ins   = (stat.kind == KIND_ADD) && !stat.table_full;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/kct_datapath.sv
module kct_datapath
  import kct_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 attr_code,
  input  logic [7:0]                 equip_type,
  input  logic [7:0]                 level,
  input  logic [AMOUNT_BITS-1:0]     amount,
  input  ctl_cmd_t                   cmd,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic                       valid_entry,
  output logic [7:0]                 attr_out,
  output logic [7:0]                 equip_out,
  output logic [7:0]                 level_out,
  output logic [COUNT_OUT_BITS-1:0]  count_out,
  output logic                       last
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WIDE   = ((COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // table memories
  logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic [USED_W-1:0]     used;
  logic [IDX_W-1:0]      idx;

  // latched request
  kind_t                 k_kind;
  logic [KEY_BITS-1:0]   k_key;
  logic [AMOUNT_BITS-1:0] k_amt;

  // held list entry
  logic                  pend_valid;
  logic [KEY_BITS-1:0]   pend_key;
  logic [COUNT_BITS-1:0] pend_cnt;

  // output register
  status_t               o_status;
  logic                  o_valid_entry;
  logic [KEY_BITS-1:0]   o_key;
  logic [COUNT_BITS-1:0] o_cnt;
  logic                  o_last;

  logic [WIDE-1:0]       sum_w;
  logic [COUNT_BITS-1:0] add_cnt;
  logic [COUNT_BITS-1:0] rem_cnt;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS-1:0] amt_sat;
  logic                  short_cnt;
  logic                  out_free;
  logic                  table_full;
  logic [IDX_W-1:0]      wr_addr;

  status_t               e_status;
  logic                  e_valid_entry;
  logic [KEY_BITS-1:0]   e_key;
  logic [COUNT_BITS-1:0] e_cnt;
  logic                  e_last;

  // count arithmetic
  always_comb begin
    sum_w     = WIDE'(rd_cnt) + WIDE'(k_amt);
    add_cnt   = (sum_w > WIDE'(CMAX)) ? CMAX : COUNT_BITS'(sum_w);
    short_cnt = WIDE'(rd_cnt) < WIDE'(k_amt);
    rem_cnt   = short_cnt ? '0 : COUNT_BITS'(WIDE'(rd_cnt) - WIDE'(k_amt));
    hit_cnt   = (k_kind == KIND_ADD) ? add_cnt : rem_cnt;
    amt_sat   = (WIDE'(k_amt) > WIDE'(CMAX)) ? CMAX : COUNT_BITS'(k_amt);
  end

  assign table_full = (used == USED_W'(TABLE_ENTRIES));
  assign out_free   = !out_valid || out_ready;
  assign wr_addr    = cmd.wr_ins ? used[IDX_W-1:0] : idx;

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      key_mem[wr_addr] <= k_key;
      cnt_mem[wr_addr] <= amt_sat;
    end else if (cmd.wr_hit) begin
      cnt_mem[wr_addr] <= hit_cnt;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key <= key_mem[idx];
      rd_cnt <= cnt_mem[idx];
    end
  end

  // fill count and sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      idx  <= '0;
    end else begin
      if (cmd.wr_ins) begin
        used <= used + USED_W'(1);
      end
      if (cmd.load_item) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k_kind <= kind_t'(kind);
      k_key  <= {attr_code, equip_type, level};
      k_amt  <= amount;
    end
  end

  // held list entry
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load_item) begin
      pend_valid <= 1'b0;
    end else if (cmd.load_pend) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_key <= rd_key;
      pend_cnt <= rd_cnt;
    end
  end

  // result selection
  always_comb begin
    e_status      = ST_UPDATED;
    e_valid_entry = 1'b0;
    e_key         = k_key;
    e_cnt         = '0;
    e_last        = 1'b1;
    case (cmd.emit_src)
      EM_HIT: begin
        e_cnt    = hit_cnt;
        e_status = (k_kind == KIND_REMOVE && short_cnt) ? ST_SHORT : ST_UPDATED;
      end
      EM_PEND: begin
        e_status      = ST_LIST;
        e_valid_entry = 1'b1;
        e_key         = pend_key;
        e_cnt         = pend_cnt;
        e_last        = 1'b0;
      end
      EM_END: begin
        case (k_kind)
          KIND_ADD: begin
            e_status = table_full ? ST_FULL : ST_INSERTED;
            e_cnt    = table_full ? '0 : amt_sat;
          end
          KIND_REMOVE: begin
            e_status = ST_NOT_FOUND;
          end
          default: begin
            // list end: last held entry, or the empty marker
            e_status      = ST_LIST;
            e_valid_entry = pend_valid;
            e_key         = pend_valid ? pend_key : '0;
            e_cnt         = pend_valid ? pend_cnt : '0;
          end
        endcase
      end
      default: begin
        e_status = ST_UPDATED;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_status      <= e_status;
      o_valid_entry <= e_valid_entry;
      o_key         <= e_key;
      o_cnt         <= e_cnt;
      o_last        <= e_last;
    end
  end

  assign status      = o_status;
  assign valid_entry = o_valid_entry;
  assign attr_out    = o_key[23:16];
  assign equip_out   = o_key[15:8];
  assign level_out   = o_key[7:0];
  assign count_out   = COUNT_OUT_BITS'(o_cnt);
  assign last        = o_last;

  // status to the controller
  always_comb begin
    stat.kind        = k_kind;
    stat.used_zero   = (used == '0);
    stat.idx_last    = ((USED_W'(idx) + USED_W'(1)) == used);
    stat.key_match   = (rd_key == k_key);
    stat.cnt_nonzero = (rd_cnt != '0);
    stat.pend_valid  = pend_valid;
    stat.table_full  = table_full;
    stat.out_free    = out_free;
  end

`ifndef NO_ASSERTIONS
  // a result is never loaded over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded while output register busy");

  // insert only into a table with room, and it grows by one
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |-> !table_full)
    else $error("insert into full table");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ins |=> (used == USED_W'($past(used) + USED_W'(1))))
    else $error("fill count did not advance on insert");

  // count update only on a matching key
  a_hit_match: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_hit |-> (rd_key == k_key))
    else $error("count written without key match");
`endif

endmodule

FILE: sv/keyed_count_table_top.sv
// add or remove sweeps the table from entry 0 and gives its result when the matching entry is found
// add or remove miss, and list, sweep up to the fill count: one table read and one compare per entry
// one request at a time: no new request is taken until the last one is done; output stalls hold it
// a list request sends one result per nonzero entry, the last at the end, or an empty marker if none
// reset (synchronous, active high) empties the table by clearing the fill count
// table memories are not cleared; no entry at or above the fill count is ever read
module keyed_count_table_top
  import kct_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 attr_code,
  input  logic [7:0]                 equip_type,
  input  logic [7:0]                 level,
  input  logic [AMOUNT_BITS-1:0]     amount,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic                       valid_entry,
  output logic [7:0]                 attr_out,
  output logic [7:0]                 equip_out,
  output logic [7:0]                 level_out,
  output logic [COUNT_OUT_BITS-1:0]  count_out,
  output logic                       last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  kct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, arithmetic and output register
  kct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .attr_code   (attr_code),
    .equip_type  (equip_type),
    .level       (level),
    .amount      (amount),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .valid_entry (valid_entry),
    .attr_out    (attr_out),
    .equip_out   (equip_out),
    .level_out   (level_out),
    .count_out   (count_out),
    .last        (last)
  );

endmodule
